// File: rtl/psrb_pkg.sv
// shared types and codes for the packet slot ring buffer
`default_nettype none
package psrb_pkg;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
    logic       last_byte;
  } psrb_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       last_of_run;
  } psrb_out_t;

  typedef struct packed {
    logic       is_pop;
    logic [7:0] data;
    logic       last;
  } psrb_item_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_LEN,
    B_STREAM
  } psrb_bstate_t;

endpackage
`default_nettype wire

// File: rtl/psrb_front.sv
// front end: accepts command beats and queues classified items
`default_nettype none
module psrb_front
  import psrb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire psrb_in_t   in_data,
  input  wire logic       take,
  output logic            item_valid,
  output psrb_item_t      item
);

  psrb_item_t q_r [2];
  logic       wr_idx_r;
  logic       rd_idx_r;
  logic [1:0] cnt_r;
  logic       accept;
  psrb_item_t cls;

  assign busy       = (cnt_r == 2'd2);
  assign accept     = start && !busy;
  assign item_valid = (cnt_r != 2'd0);
  assign item       = q_r[rd_idx_r];

  always_comb begin
    cls.is_pop = (in_data.operation == OP_POP);
    cls.data   = in_data.data_byte;
    cls.last   = in_data.last_byte;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_idx_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= 1'b0;
      rd_idx_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (accept) begin
        wr_idx_r <= ~wr_idx_r;
      end
      if (take) begin
        rd_idx_r <= ~rd_idx_r;
      end
      case ({accept, take})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/psrb_back.sv
// back end: ring pointers, slot storage, push handling and pop streaming
`default_nettype none
module psrb_back
  import psrb_pkg::*;
#(
  parameter int SLOT_COUNT = 4,
  parameter int SLOT_BYTES = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       item_valid,
  input  wire psrb_item_t item,
  output logic            take,
  output logic            out_valid,
  output psrb_out_t       out_data
);

  localparam int SLOT_W    = $clog2(SLOT_COUNT);
  localparam int IDX_W     = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
  localparam int LEN_W     = $clog2(SLOT_BYTES + 1);
  localparam int ADDR_W    = SLOT_W + IDX_W;
  localparam int MEM_DEPTH = SLOT_COUNT * (2 ** IDX_W);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);
  localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(SLOT_BYTES);
  localparam logic [LEN_W-1:0]  LEN_ONE   = LEN_W'(1);

  logic [7:0]       byte_mem [MEM_DEPTH];
  logic [LEN_W-1:0] len_mem  [SLOT_COUNT];

  psrb_bstate_t     state_r, state_nxt;
  logic [SLOT_W-1:0] wslot_r, wslot_nxt;
  logic              wmir_r, wmir_nxt;
  logic [SLOT_W-1:0] rslot_r, rslot_nxt;
  logic              rmir_r, rmir_nxt;
  logic              open_r, open_nxt;
  logic              drop_r, drop_nxt;
  logic [LEN_W-1:0]  wr_len_r, wr_len_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic              out_bv_r, out_bv_nxt;
  logic              out_last_r, out_last_nxt;

  logic [7:0]        mem_q_r;
  logic [LEN_W-1:0]  len_q_r;

  logic              mem_we, mem_re, len_we, len_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [LEN_W-1:0]  cur_len, new_len;
  logic              ring_empty, ring_full;

  assign ring_empty = (wslot_r == rslot_r) && (wmir_r == rmir_r);
  assign ring_full  = (wslot_r == rslot_r) && (wmir_r != rmir_r);
  assign cur_len    = open_r ? wr_len_r : '0;
  assign new_len    = cur_len + LEN_ONE;
  assign mem_waddr  = {wslot_r, cur_len[IDX_W-1:0]};
  assign mem_raddr  = {rslot_r, idx_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      byte_mem[mem_waddr] <= item.data;
    end
    if (mem_re) begin
      mem_q_r <= byte_mem[mem_raddr];
    end
    if (len_we) begin
      len_mem[wslot_r] <= wr_len_nxt;
    end
    if (len_re) begin
      len_q_r <= len_mem[rslot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      wslot_r      <= '0;
      wmir_r       <= 1'b0;
      rslot_r      <= '0;
      rmir_r       <= 1'b0;
      open_r       <= 1'b0;
      drop_r       <= 1'b0;
      wr_len_r     <= '0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
      out_status_r <= ST_OK;
      out_bv_r     <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wslot_r      <= wslot_nxt;
      wmir_r       <= wmir_nxt;
      rslot_r      <= rslot_nxt;
      rmir_r       <= rmir_nxt;
      open_r       <= open_nxt;
      drop_r       <= drop_nxt;
      wr_len_r     <= wr_len_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
      out_bv_r     <= out_bv_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    wslot_nxt      = wslot_r;
    wmir_nxt       = wmir_r;
    rslot_nxt      = rslot_r;
    rmir_nxt       = rmir_r;
    open_nxt       = open_r;
    drop_nxt       = drop_r;
    wr_len_nxt     = wr_len_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = ST_OK;
    out_bv_nxt     = 1'b0;
    out_last_nxt   = 1'b1;
    take           = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    len_we         = 1'b0;
    len_re         = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (item_valid) begin
          take = 1'b1;
          if (item.is_pop) begin
            if (ring_empty) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_EMPTY;
            end else begin
              len_re    = 1'b1;
              state_nxt = B_LEN;
            end
          end else begin
            out_valid_nxt = 1'b1;
            if (drop_r) begin
              out_status_nxt = ST_FULL;
              if (item.last) begin
                drop_nxt = 1'b0;
              end
            end else if (!open_r && ring_full) begin
              out_status_nxt = ST_FULL;
              if (!item.last) begin
                drop_nxt = 1'b1;
              end
            end else begin
              open_nxt = 1'b1;
              if (cur_len < LEN_MAX) begin
                mem_we     = 1'b1;
                wr_len_nxt = new_len;
              end else begin
                out_status_nxt = ST_OVERFLOW;
                wr_len_nxt     = cur_len;
              end
              if (item.last) begin
                len_we   = 1'b1;
                open_nxt = 1'b0;
                if (wslot_r == SLOT_LAST) begin
                  wslot_nxt = '0;
                  wmir_nxt  = ~wmir_r;
                end else begin
                  wslot_nxt = wslot_r + SLOT_W'(1);
                end
              end
            end
          end
        end
      end
      B_LEN: begin
        idx_nxt = '0;
        if (len_q_r == '0) begin
          out_valid_nxt = 1'b1;
          state_nxt     = B_IDLE;
          if (rslot_r == SLOT_LAST) begin
            rslot_nxt = '0;
            rmir_nxt  = ~rmir_r;
          end else begin
            rslot_nxt = rslot_r + SLOT_W'(1);
          end
        end else begin
          state_nxt = B_STREAM;
        end
      end
      B_STREAM: begin
        mem_re        = 1'b1;
        out_valid_nxt = 1'b1;
        out_bv_nxt    = 1'b1;
        out_last_nxt  = ((LEN_W'(idx_r) + LEN_ONE) == len_q_r);
        if (out_last_nxt) begin
          state_nxt = B_IDLE;
          if (rslot_r == SLOT_LAST) begin
            rslot_nxt = '0;
            rmir_nxt  = ~rmir_r;
          end else begin
            rslot_nxt = rslot_r + SLOT_W'(1);
          end
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  assign out_valid            = out_valid_r;
  assign out_data.status      = out_status_r;
  assign out_data.byte_valid  = out_bv_r;
  assign out_data.out_byte    = out_bv_r ? mem_q_r : 8'd0;
  assign out_data.last_of_run = out_last_r;

endmodule
`default_nettype wire

// File: rtl/packet_slot_ring_buffer_top.sv
// top level of the packet slot ring buffer
//
// command channel: in_data is taken at a rising edge with start high and busy
// low. operation selects a push of one packet byte (last_byte commits the
// packet) or a pop of the oldest committed packet.
// result channel: each result beat shows on out_data for one cycle with
// out_valid high; the receiver takes every beat and cannot stall.
// a two-entry queue parts the front from the back; busy is high while the
// queue holds two items.
// with an empty queue, a push or empty-pop result is registered in the queue
// entry and then in the back end's output register; a pop of n bytes goes
// through the queue, the slot length read and a byte-memory read, then
// streams one byte per cycle. a push or empty pop holds the back end only
// for its dequeue; a pop holds it for the dequeue, the length read and one
// byte-memory read per byte, and no new item is taken until the pop ends.
// reset: pointers, open/drop flags and the queue clear at once; slot storage
// is not cleared and no clearing pass runs.
`default_nettype none
module packet_slot_ring_buffer_top
  import psrb_pkg::*;
#(
  parameter int SLOT_COUNT = 4,
  parameter int SLOT_BYTES = 64
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire psrb_in_t in_data,
  output logic          out_valid,
  output psrb_out_t     out_data
);

  logic       item_valid;
  logic       take;
  psrb_item_t item;

  psrb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  psrb_back #(
    .SLOT_COUNT (SLOT_COUNT),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

// File: rtl/psrb_checker.sv
// port-level checks for the packet slot ring buffer and their bind
`default_nettype none
module psrb_checker
  import psrb_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire psrb_in_t  in_data,
  input wire logic      out_valid,
  input wire psrb_out_t out_data
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid && !busy)
    else $error("outputs active right after reset");

  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.byte_valid |-> out_data.out_byte == 8'd0)
    else $error("nonzero out_byte without byte_valid");

  a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> !out_data.byte_valid && out_data.last_of_run)
    else $error("error status beat is not a lone final beat");

  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.byte_valid |-> out_data.status == ST_OK)
    else $error("popped byte carries error status");

  a_cmd_known: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> !$isunknown(in_data))
    else $error("command beat accepted with unknown payload");

endmodule

bind packet_slot_ring_buffer_top psrb_checker u_psrb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire

// File: dv/tb_packet_slot_ring_buffer_top.sv
// self-checking testbench for the packet slot ring buffer top level
`timescale 1ns / 1ps
module tb_packet_slot_ring_buffer_top;
  import psrb_pkg::*;

  localparam int SLOTS      = 4;
  localparam int SLOT_DEPTH = 64;
  localparam int PTR_W      = $clog2(SLOTS) + 1;
  localparam int RAND_BEATS = 373;
  localparam int CYCLE_CAP  = 400000;
  localparam int NUM_ROWS   = 16;

  typedef struct {
    logic        op;
    logic [7:0]  data;
    logic        last;
    int unsigned reps;
    bit          typed;
    logic [1:0]  st;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  psrb_in_t  in_data;
  logic      out_valid;
  psrb_out_t out_data;

  // ring shadow
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  bit               pkt_open;
  bit               pkt_drop;
  logic [6:0]       slot_len [SLOTS];
  logic [7:0]       slot_mem [SLOTS][SLOT_DEPTH];

  psrb_out_t ring_results[$];
  psrb_out_t expected_beats[$];
  psrb_out_t want;
  int        err_count = 0;
  int        cycle_count = 0;
  int        beats_sent;
  bit        steady;

  dir_row_t dir_rows [NUM_ROWS] = '{
    '{OP_POP,  8'h00, 1'b0,  1, 1'b1, ST_EMPTY},
    '{OP_PUSH, 8'h00, 1'b1,  1, 1'b1, ST_OK},
    '{OP_PUSH, 8'hC0, 1'b0, 64, 1'b1, ST_OK},
    '{OP_PUSH, 8'hAA, 1'b1,  1, 1'b1, ST_OVERFLOW},
    '{OP_POP,  8'h00, 1'b0,  1, 1'b0, ST_OK},
    '{OP_POP,  8'h00, 1'b0,  1, 1'b0, ST_OK},
    '{OP_PUSH, 8'hFC, 1'b1,  4, 1'b1, ST_OK},
    '{OP_PUSH, 8'h11, 1'b1,  1, 1'b1, ST_FULL},
    '{OP_PUSH, 8'h22, 1'b0,  3, 1'b1, ST_FULL},
    '{OP_PUSH, 8'h33, 1'b1,  1, 1'b1, ST_FULL},
    '{OP_POP,  8'h00, 1'b0,  1, 1'b0, ST_OK},
    '{OP_PUSH, 8'h44, 1'b0,  1, 1'b1, ST_OK},
    '{OP_POP,  8'h00, 1'b0,  1, 1'b0, ST_OK},
    '{OP_PUSH, 8'h45, 1'b1,  1, 1'b1, ST_OK},
    '{OP_POP,  8'h00, 1'b0,  4, 1'b0, ST_OK},
    '{OP_POP,  8'hFF, 1'b1,  1, 1'b1, ST_EMPTY}
  };

  packet_slot_ring_buffer_top #(
    .SLOT_COUNT(SLOTS),
    .SLOT_BYTES(SLOT_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic psrb_in_t cmd(logic op, logic [7:0] data, logic last);
    psrb_in_t c;
    c.operation = op;
    c.data_byte = data;
    c.last_byte = last;
    return c;
  endfunction

  function automatic psrb_out_t status_beat(logic [1:0] st);
    psrb_out_t b;
    b.status      = st;
    b.byte_valid  = 1'b0;
    b.out_byte    = 8'd0;
    b.last_of_run = 1'b1;
    return b;
  endfunction

  function automatic void predict_ring(psrb_in_t it);
    logic [PTR_W-2:0] s;
    logic [6:0]       n;
    logic [1:0]       st;
    psrb_out_t        b;
    ring_results.delete();
    if (it.operation == OP_POP) begin
      if (wr_ptr == rd_ptr) begin
        ring_results.push_back(status_beat(ST_EMPTY));
      end else begin
        s = rd_ptr[PTR_W-2:0];
        n = slot_len[s];
        if (n > SLOT_DEPTH) n = 7'(SLOT_DEPTH);
        if (n == 0) begin
          ring_results.push_back(status_beat(ST_OK));
        end else begin
          for (int i = 0; i < n; i++) begin
            b.status      = ST_OK;
            b.byte_valid  = 1'b1;
            b.out_byte    = slot_mem[s][i];
            b.last_of_run = (i == n - 1);
            ring_results.push_back(b);
          end
        end
        slot_len[s] = 7'd0;
        rd_ptr = rd_ptr + 1'b1;
      end
    end else begin
      st = ST_OK;
      if (pkt_drop) begin
        st = ST_FULL;
        if (it.last_byte) pkt_drop = 1'b0;
      end else if (!pkt_open && wr_ptr != rd_ptr &&
                   wr_ptr[PTR_W-2:0] == rd_ptr[PTR_W-2:0]) begin
        st = ST_FULL;
        if (!it.last_byte) pkt_drop = 1'b1;
      end else begin
        s = wr_ptr[PTR_W-2:0];
        if (!pkt_open) begin
          pkt_open    = 1'b1;
          slot_len[s] = 7'd0;
        end
        if (slot_len[s] < SLOT_DEPTH) begin
          slot_mem[s][slot_len[s]] = it.data_byte;
          slot_len[s] = slot_len[s] + 7'd1;
        end else begin
          st = ST_OVERFLOW;
        end
        if (it.last_byte) begin
          wr_ptr   = wr_ptr + 1'b1;
          pkt_open = 1'b0;
        end
      end
      ring_results.push_back(status_beat(st));
    end
  endfunction

  task automatic report_mismatch(string field, int got, int exp_val);
    err_count++;
    if (err_count <= 30)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, exp_val);
  endtask

  // inputs change on the falling edge; a beat is taken at a rising edge with busy low
  task automatic send_beat(psrb_in_t beat, bit typed, psrb_out_t typed_beat);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 8) begin
      start = 1'b0;
      @(negedge clk);
    end
    start   = 1'b1;
    in_data = beat;
    do @(posedge clk); while (busy);
    predict_ring(beat);
    if (typed) expected_beats.push_back(typed_beat);
    else foreach (ring_results[i]) expected_beats.push_back(ring_results[i]);
    beats_sent++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat", int'(out_data), 0);
      end else begin
        want = expected_beats.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", int'(out_data.status), int'(want.status));
        if (out_data.byte_valid !== want.byte_valid)
          report_mismatch("byte_valid", int'(out_data.byte_valid), int'(want.byte_valid));
        if (out_data.out_byte !== want.out_byte)
          report_mismatch("out_byte", int'(out_data.out_byte), int'(want.out_byte));
        if (out_data.last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", int'(out_data.last_of_run),
                          int'(want.last_of_run));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int        base;
    int        pick;
    int        plen;
    bit        drained;
    bit        close_pkt;
    psrb_out_t none;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    beats_sent  = 0;
    steady      = 1'b0;
    drained     = 1'b0;
    none        = '0;
    wr_ptr      = '0;
    rd_ptr      = '0;
    pkt_open    = 1'b0;
    pkt_drop    = 1'b0;
    foreach (slot_len[i]) slot_len[i] = 7'd0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[r]) begin
      for (int k = 0; k < dir_rows[r].reps; k++)
        send_beat(cmd(dir_rows[r].op, dir_rows[r].data + 8'(k), dir_rows[r].last),
                  dir_rows[r].typed, status_beat(dir_rows[r].st));
    end

    base = beats_sent;
    while (beats_sent - base < RAND_BEATS) begin
      steady = (beats_sent - base >= 120) && (beats_sent - base < 240);
      if (!drained && beats_sent - base >= 300) begin
        // hold off until the result stream is fully drained
        @(negedge clk);
        start = 1'b0;
        while (expected_beats.size() != 0) @(posedge clk);
        drained = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_beat(cmd(1'($urandom_range(1)), 8'($urandom_range(255)),
                      1'($urandom_range(1))), 1'b0, none);
      end else if (pick < 45) begin
        send_beat(cmd(OP_POP, 8'($urandom_range(255)), 1'b0), 1'b0, none);
      end else begin
        pick = $urandom_range(99);
        if (pick < 65)      plen = $urandom_range(4, 1);
        else if (pick < 85) plen = $urandom_range(20, 5);
        else if (pick < 95) plen = $urandom_range(64, 21);
        else                plen = $urandom_range(70, 63);
        // now and then a packet is left open and runs into the next one
        close_pkt = ($urandom_range(99) >= 5);
        for (int k = 0; k < plen; k++) begin
          if ($urandom_range(99) < 3)
            send_beat(cmd(OP_POP, 8'($urandom_range(255)), 1'b0), 1'b0, none);
          send_beat(cmd(OP_PUSH, 8'($urandom_range(255)), close_pkt && (k == plen - 1)),
                    1'b0, none);
        end
      end
    end

    @(negedge clk);
    start = 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
